// ===== sv/mfs_pkg.sv =====
package mfs_pkg;

	localparam int MAX_LAYERS   = 8;
	localparam int MAX_NODES    = 64;
	localparam int DATA_W       = 16;
	localparam int ACC_W        = 40;
	localparam int SIG_DEPTH    = 256;
	localparam int FRAC_BITS    = 12;
	localparam int LI_W         = 3;
	localparam int NODE_W       = 6;
	localparam int CNT_W        = 7;
	localparam int NL_W         = 4;
	localparam int SIG_W        = 13;
	localparam int WEIGHT_DEPTH = (MAX_LAYERS - 1) * MAX_NODES * MAX_NODES;
	localparam int WADDR_W      = LI_W + 2 * NODE_W;
	localparam int SIG_IDX_W    = 8;
	localparam int SIG_STEP     = (1 << (DATA_W - 1)) / SIG_DEPTH;
	localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

	typedef enum logic [1:0] {
		REQ_SIZE   = 2'd0,
		REQ_WEIGHT = 2'd1,
		REQ_ACT    = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_RANGE   = 2'd1,
		STAT_DONE    = 2'd2,
		STAT_NO_RES  = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD_WAIT,
		BK_LD_IN,
		BK_LD_OUT,
		BK_MAC,
		BK_ACT,
		BK_DONE
	} bk_state_t;

	// decoded item as it sits in the queue
	typedef struct packed {
		req_t                     kind;
		logic                     bad;
		logic [LI_W-1:0]          layer_index;
		logic [NODE_W-1:0]        from_node;
		logic [NODE_W-1:0]        to_node;
		logic [CNT_W-1:0]         node_count;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic empty;
	} q_ctl_t;

	typedef logic [SIG_W-1:0] sig_rom_t [SIG_DEPTH];

	// shift-subtract quotient, only used while building the rom
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid of each segment midpoint in Q1.12, Q30 series for exp
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t rom;
		longint xq;
		longint unsigned a, n, f, term, pos, neg, e, den, s, k;
		for (int m = 0; m < SIG_DEPTH; m++) begin
			xq = longint'((2 * m + 1) * SIG_STEP) -
				longint'(1 << (DATA_W - 1));
			a = (xq < 0) ? longint'(-xq) : longint'(xq);
			n = a >> FRAC_BITS;
			f = (a & 64'd4095) << (30 - FRAC_BITS);
			term = 64'd1 << 30;
			pos = term;
			neg = 64'd0;
			for (k = 64'd1; k <= 64'd16; k++) begin
				term = udiv((term * f) >> 30, k);
				if (k[0]) neg = neg + term;
				else pos = pos + term;
			end
			e = pos - neg;
			for (k = 64'd0; k < n && k < 64'd64; k++)
				e = (e * EXP_M1_Q30 + (64'd1 << 29)) >> 30;
			den = (64'd1 << 30) + e;
			s = udiv((64'd4096 << 30) + (den >> 1), den);
			if (xq < 0) s = 64'd4096 - s;
			rom[m] = s[SIG_W-1:0];
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== sv/mfs_if.sv =====
interface mfs_in_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic [mfs_pkg::LI_W-1:0]         layer_index;
	logic [mfs_pkg::NODE_W-1:0]       from_node;
	logic [mfs_pkg::NODE_W-1:0]       to_node;
	logic [mfs_pkg::CNT_W-1:0]        node_count;
	logic signed [mfs_pkg::DATA_W-1:0] value;
	logic                             last;
	modport source (output valid, req_type, layer_index, from_node, to_node, node_count,
		value, last, input ready);
	modport sink (input valid, req_type, layer_index, from_node, to_node, node_count,
		value, last, output ready);
endinterface

interface mfs_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [mfs_pkg::DATA_W-1:0] data;
	logic [mfs_pkg::CNT_W-1:0]         output_count;
	modport source (output valid, status, data, output_count, input ready);
	modport sink (input valid, status, data, output_count, output ready);
endinterface

interface mfs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mfs_pkg::NL_W-1:0]   data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== sv/mfs_front.sv =====
module mfs_front (
	mfs_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            q_push,
	output mfs_pkg::cmd_t   q_cmd
);

	mfs_pkg::req_t kind;
	logic          bad;

	assign kind = mfs_pkg::req_t'(in_ch.req_type);

	// range checks that need no stored state
	always_comb begin
		unique case (kind)
			mfs_pkg::REQ_SIZE:   bad = (in_ch.node_count == '0) ||
				(in_ch.node_count > mfs_pkg::CNT_W'(mfs_pkg::MAX_NODES));
			mfs_pkg::REQ_WEIGHT: bad = (in_ch.layer_index >=
				mfs_pkg::LI_W'(mfs_pkg::MAX_LAYERS - 1));
			default:             bad = 1'b0;
		endcase
	end

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	always_comb begin
		q_cmd.kind        = kind;
		q_cmd.bad         = bad;
		q_cmd.layer_index = in_ch.layer_index;
		q_cmd.from_node   = in_ch.from_node;
		q_cmd.to_node     = in_ch.to_node;
		q_cmd.node_count  = in_ch.node_count;
		q_cmd.value       = in_ch.value;
		q_cmd.last        = in_ch.last;
	end

endmodule

// ===== sv/mfs_queue.sv =====
module mfs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfs_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output mfs_pkg::cmd_t  head,
	output logic           full,
	output logic           empty
);

	mfs_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== sv/mfs_back.sv =====
module mfs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mfs_pkg::cmd_t   head,
	input  mfs_pkg::q_ctl_t q_ctl,
	output logic            pop,
	mfs_cfg_if.sink         cfg_ch,
	mfs_out_if.source       out_ch
);

	localparam int AW = mfs_pkg::NODE_W;

	mfs_pkg::bk_state_t state_q, state_nx;

	logic [mfs_pkg::NL_W-1:0]  num_layers_q;
	logic [mfs_pkg::CNT_W-1:0] lsz_q [mfs_pkg::MAX_LAYERS];
	logic                      res_valid_q;
	logic                      res_pong_q;

	logic signed [mfs_pkg::DATA_W-1:0] wmem [mfs_pkg::WEIGHT_DEPTH];
	logic signed [mfs_pkg::DATA_W-1:0] ping [mfs_pkg::MAX_NODES];
	logic signed [mfs_pkg::DATA_W-1:0] pong [mfs_pkg::MAX_NODES];
	logic signed [mfs_pkg::DATA_W-1:0] w_rd_s1, ping_rd_s1, pong_rd_s1;
	logic signed [2*mfs_pkg::DATA_W-1:0] prod_s2;
	logic                               rd_v_s1, prod_v_s2;
	logic signed [mfs_pkg::ACC_W-1:0]   acc_q;

	logic [mfs_pkg::LI_W-1:0]  l_q;
	logic [mfs_pkg::CNT_W-1:0] i_q, j_q, nin_q, nout_q;

	logic                      out_valid_q;
	mfs_pkg::stat_t            out_stat_q;
	logic signed [mfs_pkg::DATA_W-1:0] out_data_q;
	logic [mfs_pkg::CNT_W-1:0] out_cnt_q;

	logic [mfs_pkg::LI_W-1:0]  last_li;
	logic [mfs_pkg::LI_W-1:0]  lsz_addr;
	logic [mfs_pkg::CNT_W-1:0] lsz_rd;
	logic                      out_free, ready_go;
	logic                      issue;
	logic                      mac_done;
	logic                      layer_end;
	logic [AW-1:0]             act_rd_addr;
	logic signed [mfs_pkg::DATA_W-1:0] src_rd;
	logic signed [mfs_pkg::DATA_W-1:0] x16;
	logic [mfs_pkg::SIG_IDX_W-1:0]     sig_idx;
	logic signed [mfs_pkg::DATA_W-1:0] sig_val;

	// control from the output decode
	logic                      do_size, do_weight, do_ping_in, do_start;
	logic                      ld_out;
	mfs_pkg::stat_t            ld_stat;
	logic                      ld_cnt;

	always_comb begin
		if (num_layers_q < mfs_pkg::NL_W'(2)) last_li = mfs_pkg::LI_W'(1);
		else if (num_layers_q > mfs_pkg::NL_W'(mfs_pkg::MAX_LAYERS))
			last_li = mfs_pkg::LI_W'(mfs_pkg::MAX_LAYERS - 1);
		else last_li = mfs_pkg::LI_W'(num_layers_q - mfs_pkg::NL_W'(1));
	end

	// one read port on the size table
	always_comb begin
		unique case (state_q)
			mfs_pkg::BK_LD_IN:  lsz_addr = l_q;
			mfs_pkg::BK_LD_OUT: lsz_addr = l_q + mfs_pkg::LI_W'(1);
			mfs_pkg::BK_DONE:   lsz_addr = last_li;
			default:            lsz_addr = (head.kind == mfs_pkg::REQ_ACT) ? '0 : last_li;
		endcase
	end
	assign lsz_rd = lsz_q[lsz_addr];

	assign out_free = !out_valid_q || out_ch.ready;
	assign ready_go = (state_q == mfs_pkg::BK_IDLE) && !q_ctl.empty && out_free;
	assign pop      = ready_go;

	assign issue     = (state_q == mfs_pkg::BK_MAC) && (j_q < nin_q);
	assign mac_done  = (state_q == mfs_pkg::BK_MAC) && (j_q == nin_q) && !rd_v_s1 && !prod_v_s2;
	assign layer_end = (i_q + mfs_pkg::CNT_W'(1) == nout_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mfs_pkg::BK_IDLE: begin
				if (ready_go) begin
					if (head.kind == mfs_pkg::REQ_READ && res_valid_q &&
						mfs_pkg::CNT_W'(head.to_node) < lsz_rd)
						state_nx = mfs_pkg::BK_RD_WAIT;
					else if (head.kind == mfs_pkg::REQ_ACT && head.last &&
						mfs_pkg::CNT_W'(head.from_node) < lsz_rd)
						state_nx = mfs_pkg::BK_LD_IN;
				end
			end
			mfs_pkg::BK_RD_WAIT: state_nx = mfs_pkg::BK_IDLE;
			mfs_pkg::BK_LD_IN:   state_nx = mfs_pkg::BK_LD_OUT;
			mfs_pkg::BK_LD_OUT:  state_nx = mfs_pkg::BK_MAC;
			mfs_pkg::BK_MAC:     if (mac_done) state_nx = mfs_pkg::BK_ACT;
			mfs_pkg::BK_ACT: begin
				if (!layer_end) state_nx = mfs_pkg::BK_MAC;
				else if (l_q + mfs_pkg::LI_W'(1) == last_li) state_nx = mfs_pkg::BK_DONE;
				else state_nx = mfs_pkg::BK_LD_IN;
			end
			mfs_pkg::BK_DONE:    state_nx = mfs_pkg::BK_IDLE;
			default:             state_nx = mfs_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		do_size    = 1'b0;
		do_weight  = 1'b0;
		do_ping_in = 1'b0;
		do_start   = 1'b0;
		ld_out     = 1'b0;
		ld_stat    = mfs_pkg::STAT_OK;
		ld_cnt     = 1'b0;
		unique case (state_q)
			mfs_pkg::BK_IDLE: begin
				if (ready_go) begin
					unique case (head.kind)
						mfs_pkg::REQ_SIZE: begin
							ld_out  = 1'b1;
							ld_stat = head.bad ? mfs_pkg::STAT_RANGE : mfs_pkg::STAT_OK;
							do_size = !head.bad;
						end
						mfs_pkg::REQ_WEIGHT: begin
							ld_out    = 1'b1;
							ld_stat   = head.bad ? mfs_pkg::STAT_RANGE : mfs_pkg::STAT_OK;
							do_weight = !head.bad;
						end
						mfs_pkg::REQ_ACT: begin
							if (mfs_pkg::CNT_W'(head.from_node) >= lsz_rd) begin
								ld_out  = 1'b1;
								ld_stat = mfs_pkg::STAT_RANGE;
							end else begin
								do_ping_in = 1'b1;
								do_start   = head.last;
								ld_out     = !head.last;
							end
						end
						mfs_pkg::REQ_READ: begin
							// a good read loads the result in the next cycle, from BK_RD_WAIT
							if (!res_valid_q) begin
								ld_out  = 1'b1;
								ld_stat = mfs_pkg::STAT_NO_RES;
							end else if (mfs_pkg::CNT_W'(head.to_node) >= lsz_rd) begin
								ld_out  = 1'b1;
								ld_stat = mfs_pkg::STAT_RANGE;
							end
						end
						default: ld_out = 1'b0;
					endcase
				end
			end
			mfs_pkg::BK_RD_WAIT: ld_out = 1'b1;
			mfs_pkg::BK_DONE: begin
				ld_out  = 1'b1;
				ld_stat = mfs_pkg::STAT_DONE;
				ld_cnt  = 1'b1;
			end
			default: ld_out = 1'b0;
		endcase
	end

	// activation read address: the output read or the mac source element
	assign act_rd_addr = (state_q == mfs_pkg::BK_MAC) ? j_q[AW-1:0] : head.to_node;
	assign src_rd      = l_q[0] ? pong_rd_s1 : ping_rd_s1;

	// floor shift to Q4.12 with saturation, then the rom lookup
	always_comb begin
		if (acc_q[mfs_pkg::ACC_W-1:mfs_pkg::FRAC_BITS+mfs_pkg::DATA_W-1] == '0 ||
			acc_q[mfs_pkg::ACC_W-1:mfs_pkg::FRAC_BITS+mfs_pkg::DATA_W-1] == '1)
			x16 = acc_q[mfs_pkg::FRAC_BITS+mfs_pkg::DATA_W-1:mfs_pkg::FRAC_BITS];
		else if (acc_q[mfs_pkg::ACC_W-1])
			x16 = {1'b1, {(mfs_pkg::DATA_W-1){1'b0}}};
		else
			x16 = {1'b0, {(mfs_pkg::DATA_W-1){1'b1}}};
	end
	assign sig_idx = {~x16[mfs_pkg::DATA_W-1],
		x16[mfs_pkg::DATA_W-2:mfs_pkg::DATA_W-mfs_pkg::SIG_IDX_W]};
	assign sig_val = mfs_pkg::DATA_W'(mfs_pkg::SIG_ROM[sig_idx]);

	// memories
	always_ff @(posedge clk) begin
		if (do_weight)
			wmem[{head.layer_index, head.from_node, head.to_node}] <= head.value;
		w_rd_s1 <= wmem[{l_q, j_q[AW-1:0], i_q[AW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (do_ping_in)
			ping[head.from_node] <= head.value;
		else if (state_q == mfs_pkg::BK_ACT && l_q[0])
			ping[i_q[AW-1:0]] <= sig_val;
		ping_rd_s1 <= ping[act_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == mfs_pkg::BK_ACT && !l_q[0])
			pong[i_q[AW-1:0]] <= sig_val;
		pong_rd_s1 <= pong[act_rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= src_rd * w_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mfs_pkg::BK_IDLE;
			num_layers_q <= mfs_pkg::NL_W'(2);
			for (int k = 0; k < mfs_pkg::MAX_LAYERS; k++) lsz_q[k] <= mfs_pkg::CNT_W'(1);
			res_valid_q  <= 1'b0;
			res_pong_q   <= 1'b0;
			rd_v_s1      <= 1'b0;
			prod_v_s2    <= 1'b0;
			acc_q        <= '0;
			l_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			nin_q        <= '0;
			nout_q       <= '0;
			out_valid_q  <= 1'b0;
			out_stat_q   <= mfs_pkg::STAT_OK;
			out_data_q   <= '0;
			out_cnt_q    <= '0;
		end else begin
			state_q   <= state_nx;
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
			if (cfg_ch.valid) begin
				num_layers_q <= cfg_ch.data;
				res_valid_q  <= 1'b0;
			end
			if (do_size) begin
				lsz_q[head.layer_index] <= head.node_count;
				res_valid_q <= 1'b0;
			end
			if (do_ping_in) res_valid_q <= 1'b0;
			if (do_start) l_q <= '0;
			if (state_q == mfs_pkg::BK_LD_IN) nin_q <= lsz_rd;
			if (state_q == mfs_pkg::BK_LD_OUT) begin
				nout_q <= lsz_rd;
				i_q    <= '0;
				j_q    <= '0;
				acc_q  <= '0;
			end
			if (issue) j_q <= j_q + mfs_pkg::CNT_W'(1);
			if (prod_v_s2) acc_q <= acc_q + mfs_pkg::ACC_W'(prod_s2);
			if (state_q == mfs_pkg::BK_ACT) begin
				i_q   <= i_q + mfs_pkg::CNT_W'(1);
				j_q   <= '0;
				acc_q <= '0;
				if (layer_end) l_q <= l_q + mfs_pkg::LI_W'(1);
			end
			if (state_q == mfs_pkg::BK_DONE) begin
				res_valid_q <= 1'b1;
				res_pong_q  <= last_li[0];
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
				out_stat_q  <= ld_stat;
				out_cnt_q   <= ld_cnt ? lsz_rd : '0;
				out_data_q  <= (state_q == mfs_pkg::BK_RD_WAIT) ?
					(res_pong_q ? pong_rd_s1 : ping_rd_s1) : '0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ch.ready        = 1'b1;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = out_stat_q;
	assign out_ch.data         = out_data_q;
	assign out_ch.output_count = out_cnt_q;

`ifndef SYNTH
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_ctl.empty) else $error("pop from empty queue");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfs_pkg::BK_DONE) |-> !out_valid_q) else $error("result register busy");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfs_pkg::BK_MAC) |-> (j_q <= nin_q)) else $error("mac overrun");
	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mfs_pkg::BK_IDLE) |-> !pop) else $error("pop while busy");
`endif

endmodule

// ===== sv/mlp_forward_sigmoid.sv =====
// channel   dir  beat
// in_ch     in   one request: size, weight, input activation or read
// out_ch    out  one status beat per request
// cfg_ch    in   num_layers write
//
// size and weight requests finish in BK_IDLE; a good read passes through BK_RD_WAIT
// an input activation with last set runs LD_IN, LD_OUT, then MAC and ACT per
//   output node, each layer, then DONE, on the single multiply-accumulate loop
// a two-entry queue lets requests land while the back end is busy
// reset is asynchronous, active low; memories hold no reset
module mlp_forward_sigmoid (
	input  logic       clk,
	input  logic       arst_n,
	mfs_in_if.sink     in_ch,
	mfs_out_if.source  out_ch,
	mfs_cfg_if.sink    cfg_ch
);

	mfs_pkg::cmd_t   push_cmd, head;
	mfs_pkg::q_ctl_t q_ctl;
	logic            push, pop, full, empty;

	always_comb begin
		q_ctl.push  = push;
		q_ctl.full  = full;
		q_ctl.pop   = pop;
		q_ctl.empty = empty;
	end

	mfs_front u_front (
		.in_ch  (in_ch),
		.q_full (full),
		.q_push (push),
		.q_cmd  (push_cmd)
	);

	mfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	mfs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_ctl  (q_ctl),
		.pop    (pop),
		.cfg_ch (cfg_ch),
		.out_ch (out_ch)
	);

endmodule
